// ===== design/eno3_face_reconstruction_macros.svh =====
// Assertion macros shared by the checker of the ENO3 face reconstruction block.
`ifndef ENO3_FACE_RECONSTRUCTION_MACROS_SVH
`define ENO3_FACE_RECONSTRUCTION_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ENO3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define ENO3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ENO3_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/eno3_pkg.sv =====
// Package of shared types, constants and helpers for the ENO3 face reconstruction block.
`timescale 1ns / 1ps

package eno3_pkg;

    // Fixed field widths of the transactions.
    localparam int VALUE_WIDTH    = 32;
    localparam int COMP_WIDTH     = 2;
    localparam int COMPONENTS_DEF = 4;

    // Sliding window of the last four values per component.
    localparam int WIN        = 4;
    localparam int FILL_WIDTH = $clog2(WIN + 1);

    // Depth of the queue between the front and back parts (a power of two).
    localparam int Q_DEPTH_DEF = 4;

    // Stencil codes reported with each result.
    localparam logic [1:0] STENCIL_LEFT   = 2'd0;
    localparam logic [1:0] STENCIL_CENTRE = 2'd1;
    localparam logic [1:0] STENCIL_RIGHT  = 2'd2;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [VALUE_WIDTH+1:0] diff2_t;

    // Input transaction.
    typedef struct packed {
        value_t                cell_value;
        logic [COMP_WIDTH-1:0] component;
        logic                  restart;
    } s_item_t;

    // Result transaction.
    typedef struct packed {
        value_t                plus_face;
        value_t                minus_face;
        logic [COMP_WIDTH-1:0] component_out;
        logic [1:0]            stencil_choice;
    } m_item_t;

    // Five-cell stencil handed from the front part to the back part.
    typedef struct packed {
        value_t                u0;
        value_t                u1;
        value_t                u2;
        value_t                u3;
        value_t                u4;
        logic [COMP_WIDTH-1:0] comp;
    } work_t;

    // Magnitude of a second-difference-wide value; the most negative value maps correctly.
    function automatic logic [VALUE_WIDTH+1:0] mag(diff2_t v);
        return v[VALUE_WIDTH+1] ? (VALUE_WIDTH + 2)'(-v) : (VALUE_WIDTH + 2)'(v);
    endfunction

endpackage

// ===== design/eno3_fifo.sv =====
// Short queue of pending five-cell stencils between the front and back parts.
`timescale 1ns / 1ps

module eno3_fifo #(
    parameter int DEPTH = eno3_pkg::Q_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  eno3_pkg::work_t push_data,
    output logic            full,
    input  logic            pop,
    output eno3_pkg::work_t pop_data,
    output logic            empty
);
    import eno3_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    work_t           slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;
    logic            do_push, do_pop;

    // Status and guarded handshakes.
    assign full     = (count_reg == (PW + 1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + (PW + 1)'(1);
            2'b01:   count_next = count_reg - (PW + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots; no reset needed as a slot is only read after it is written.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/eno3_front.sv =====
// Front part: accepts cell averages, keeps the per-component windows and issues full stencils.
`timescale 1ns / 1ps

module eno3_front #(
    parameter int COMPONENTS = eno3_pkg::COMPONENTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  eno3_pkg::s_item_t s_data,
    output logic              push,
    output eno3_pkg::work_t   push_data,
    input  logic              full
);
    import eno3_pkg::*;

    localparam int CIW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

    value_t                win_reg  [COMPONENTS][WIN];
    logic [FILL_WIDTH-1:0] fill_reg [COMPONENTS];
    logic [FILL_WIDTH-1:0] fill_eff, fill_next;
    logic [CIW-1:0]        cidx;
    logic                  accept, in_range, produce;

    // A transaction is taken whenever the queue has room for a stencil.
    assign s_ready  = !full;
    assign accept   = s_valid && s_ready;
    assign in_range = int'(s_data.component) < COMPONENTS;
    assign cidx     = CIW'(s_data.component);

    // Classify: a restart empties the window, a full window yields a stencil.
    always_comb begin
        fill_eff  = s_data.restart ? '0 : fill_reg[cidx];
        produce   = fill_eff >= FILL_WIDTH'(WIN);
        fill_next = produce ? FILL_WIDTH'(WIN) : fill_eff + FILL_WIDTH'(1);
    end

    // Stencil for the middle cell of the four held values and the new one.
    always_comb begin
        push           = accept && in_range && produce;
        push_data.u0   = win_reg[cidx][0];
        push_data.u1   = win_reg[cidx][1];
        push_data.u2   = win_reg[cidx][2];
        push_data.u3   = win_reg[cidx][3];
        push_data.u4   = s_data.cell_value;
        push_data.comp = s_data.component;
    end

    // Fill counts per component.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < COMPONENTS; k++) begin
                fill_reg[k] <= '0;
            end
        end else if (accept && in_range) begin
            fill_reg[cidx] <= fill_next;
        end
    end

    // Window shift; entries are only read once the fill count shows them written.
    always_ff @(posedge aclk) begin
        if (accept && in_range) begin
            for (int k = 0; k < WIN - 1; k++) begin
                win_reg[cidx][k] <= win_reg[cidx][k+1];
            end
            win_reg[cidx][WIN-1] <= s_data.cell_value;
        end
    end

endmodule

// ===== design/eno3_back.sv =====
// Back part: stencil choice, face sums and rounding division by 24, as a stalled pipeline.
`timescale 1ns / 1ps

module eno3_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  eno3_pkg::work_t   in_data,
    output logic              m_valid,
    input  logic              m_ready,
    output eno3_pkg::m_item_t m_data
);
    import eno3_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int DW = VW + 1;          // first differences
    localparam int EW = VW + 2;          // second differences
    localparam int SW = VW + 8;          // faces scaled by 24
    localparam int MW = VW + 2;          // offset quotient by 8
    localparam int HL = MW / 2;          // low chunk of the long division by 3
    localparam int HH = MW - HL;         // high chunk of the long division by 3

    // Reciprocals of 3 that are exact over each chunk's range.
    localparam logic [HH:0]   MH = (HH + 1)'(((64'd1 << (HH + 2)) + 64'd2) / 64'd3);
    localparam logic [HL+2:0] ML = (HL + 3)'(((64'd1 << (HL + 4)) + 64'd2) / 64'd3);

    // Saturation limits on the rounded sum and the offset that makes it non-negative.
    localparam logic signed [SW-1:0] FACE_HI_LIM = SW'(3) << (VW + 2);
    localparam logic signed [SW-1:0] FACE_LO_LIM = -FACE_HI_LIM;
    localparam logic signed [SW-1:0] M_OFF       = SW'(3) << (VW - 1);

    typedef struct packed {
        logic signed [DW-1:0]  dm;
        logic signed [DW-1:0]  dp;
        logic signed [DW-1:0]  dl;
        logic signed [DW-1:0]  dr;
        value_t                u2;
        logic [COMP_WIDTH-1:0] comp;
    } st1_t;

    typedef struct packed {
        logic signed [EW-1:0]  dm;
        logic signed [EW-1:0]  dp;
        logic signed [EW-1:0]  d2_left;
        logic signed [EW-1:0]  d2_mid;
        logic signed [EW-1:0]  d2_right;
        logic                  dm_le;
        value_t                u2;
        logic [COMP_WIDTH-1:0] comp;
    } st2_t;

    typedef struct packed {
        logic signed [SW-1:0]  base;
        logic signed [SW-1:0]  pt;
        logic signed [SW-1:0]  mt;
        logic [1:0]            sel;
        logic [COMP_WIDTH-1:0] comp;
    } st3_t;

    typedef struct packed {
        logic signed [SW-1:0]  np;
        logic signed [SW-1:0]  nm;
        logic [1:0]            sel;
        logic [COMP_WIDTH-1:0] comp;
    } st4_t;

    typedef struct packed {
        logic          sat_hi;
        logic          sat_lo;
        logic [HH-1:0] hi;
        logic [HL-1:0] lo;
        logic [HH-2:0] qh;
    } fdiv_t;

    typedef struct packed {
        fdiv_t                 fp;
        fdiv_t                 fm;
        logic [1:0]            sel;
        logic [COMP_WIDTH-1:0] comp;
    } st5_t;

    typedef struct packed {
        logic          sat_hi;
        logic          sat_lo;
        logic [HH-2:0] qh;
        logic [HL-1:0] ql;
    } fquo_t;

    typedef struct packed {
        fquo_t                 fp;
        fquo_t                 fm;
        logic [1:0]            sel;
        logic [COMP_WIDTH-1:0] comp;
    } st6_t;

    st1_t    s1_reg, s1_next;
    st2_t    s2_reg, s2_next;
    st3_t    s3_reg, s3_next;
    st4_t    s4_reg, s4_next;
    st5_t    s5_reg, s5_next;
    st6_t    s6_reg, s6_next;
    logic [5:0] vld_reg;
    logic    m_valid_reg;
    m_item_t m_data_reg, m_data_next;
    logic    adv;

    // Offset the sum, split it and divide the high chunk by 3.
    function automatic fdiv_t face_split(logic signed [SW-1:0] n);
        logic signed [SW-1:0] n8;
        logic signed [SW-1:0] m;
        logic [2*HH:0]        a_ext;
        logic [2*HH:0]        b_ext;
        logic [2*HH:0]        prod;
        fdiv_t                r;
        n8       = n >>> 3;
        m        = n8 + M_OFF;
        r.sat_hi = n >= FACE_HI_LIM;
        r.sat_lo = n < FACE_LO_LIM;
        r.hi     = m[MW-1:HL];
        r.lo     = m[HL-1:0];
        a_ext    = (2 * HH + 1)'(r.hi);
        b_ext    = (2 * HH + 1)'(MH);
        prod     = a_ext * b_ext;
        r.qh     = prod[2*HH:HH+2];
        return r;
    endfunction

    // Carry the high remainder into the low chunk and divide that by 3.
    function automatic fquo_t face_finish(fdiv_t d);
        logic [HH-1:0]   rem_full;
        logic [HL+1:0]   low;
        logic [2*HL+4:0] a_ext;
        logic [2*HL+4:0] b_ext;
        logic [2*HL+4:0] prod;
        fquo_t           r;
        rem_full = d.hi - (HH'(d.qh) << 1) - HH'(d.qh);
        low      = {rem_full[1:0], d.lo};
        a_ext    = (2 * HL + 5)'(low);
        b_ext    = (2 * HL + 5)'(ML);
        prod     = a_ext * b_ext;
        r.sat_hi = d.sat_hi;
        r.sat_lo = d.sat_lo;
        r.qh     = d.qh;
        r.ql     = prod[HL+4 +: HL];
        return r;
    endfunction

    // Join the quotient chunks, remove the offset and saturate.
    function automatic value_t face_out(fquo_t q);
        logic [MW-2:0] qm;
        value_t        r;
        qm = {q.qh, q.ql};
        if (q.sat_hi) begin
            r = {1'b0, {(VW - 1){1'b1}}};
        end else if (q.sat_lo) begin
            r = {1'b1, {(VW - 1){1'b0}}};
        end else begin
            r = {~qm[VW-1], qm[VW-2:0]};
        end
        return r;
    endfunction

    // The whole pipeline moves whenever the output register can take a result.
    assign adv      = !m_valid_reg || m_ready;
    assign in_ready = adv;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Stage 1: first differences.
    always_comb begin
        s1_next.dm   = DW'(in_data.u2) - DW'(in_data.u1);
        s1_next.dp   = DW'(in_data.u3) - DW'(in_data.u2);
        s1_next.dl   = DW'(in_data.u1) - DW'(in_data.u0);
        s1_next.dr   = DW'(in_data.u4) - DW'(in_data.u3);
        s1_next.u2   = in_data.u2;
        s1_next.comp = in_data.comp;
    end

    // Stage 2: second differences and the first-difference comparison.
    always_comb begin
        s2_next.dm       = EW'(s1_reg.dm);
        s2_next.dp       = EW'(s1_reg.dp);
        s2_next.d2_left  = EW'(s1_reg.dm) - EW'(s1_reg.dl);
        s2_next.d2_mid   = EW'(s1_reg.dp) - EW'(s1_reg.dm);
        s2_next.d2_right = EW'(s1_reg.dr) - EW'(s1_reg.dp);
        s2_next.dm_le    = mag(EW'(s1_reg.dm)) <= mag(EW'(s1_reg.dp));
        s2_next.u2       = s1_reg.u2;
        s2_next.comp     = s1_reg.comp;
    end

    // Stage 3: stencil choice and the correction terms of both faces.
    always_comb begin
        logic signed [SW-1:0] e_dm, e_dp, e_l, e_c, e_r, e_u2, e_s;
        e_dm = SW'(s2_reg.dm);
        e_dp = SW'(s2_reg.dp);
        e_l  = SW'(s2_reg.d2_left);
        e_c  = SW'(s2_reg.d2_mid);
        e_r  = SW'(s2_reg.d2_right);
        e_u2 = SW'(s2_reg.u2);
        e_s  = e_dp + e_dm;

        // Ties go to the left, then the centred stencil.
        if (s2_reg.dm_le) begin
            s3_next.sel = (mag(s2_reg.d2_left) <= mag(s2_reg.d2_mid))
                          ? STENCIL_LEFT : STENCIL_CENTRE;
        end else begin
            s3_next.sel = (mag(s2_reg.d2_mid) <= mag(s2_reg.d2_right))
                          ? STENCIL_CENTRE : STENCIL_RIGHT;
        end

        s3_next.base = (e_u2 <<< 4) + (e_u2 <<< 3);
        unique case (s3_next.sel)
            STENCIL_LEFT: begin
                s3_next.pt = (e_dm <<< 3) + (e_dm <<< 2) + (e_l <<< 3);
                s3_next.mt = -((e_dm <<< 3) + (e_dm <<< 2)) - (e_l <<< 2);
            end
            STENCIL_CENTRE: begin
                s3_next.pt = (e_s <<< 2) + (e_s <<< 1) + (e_c <<< 1);
                s3_next.mt = (e_c <<< 1) - ((e_s <<< 2) + (e_s <<< 1));
            end
            default: begin
                s3_next.pt = (e_dp <<< 3) + (e_dp <<< 2) - (e_r <<< 2);
                s3_next.mt = (e_r <<< 3) - ((e_dp <<< 3) + (e_dp <<< 2));
            end
        endcase
        s3_next.comp = s2_reg.comp;
    end

    // Stage 4: face sums scaled by 24, with half a step added for rounding.
    always_comb begin
        s4_next.np   = s3_reg.base + s3_reg.pt + SW'(12);
        s4_next.nm   = s3_reg.base + s3_reg.mt + SW'(12);
        s4_next.sel  = s3_reg.sel;
        s4_next.comp = s3_reg.comp;
    end

    // Stage 5 and 6: floor division by 24 as a shift and two chunks divided by 3.
    always_comb begin
        s5_next.fp   = face_split(s4_reg.np);
        s5_next.fm   = face_split(s4_reg.nm);
        s5_next.sel  = s4_reg.sel;
        s5_next.comp = s4_reg.comp;

        s6_next.fp   = face_finish(s5_reg.fp);
        s6_next.fm   = face_finish(s5_reg.fm);
        s6_next.sel  = s5_reg.sel;
        s6_next.comp = s5_reg.comp;
    end

    // Output register contents.
    always_comb begin
        m_data_next.plus_face      = face_out(s6_reg.fp);
        m_data_next.minus_face     = face_out(s6_reg.fm);
        m_data_next.component_out  = s6_reg.comp;
        m_data_next.stencil_choice = s6_reg.sel;
    end

    // Stage valid flags and the output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[4:0], in_valid};
            m_valid_reg <= vld_reg[5];
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            s3_reg     <= s3_next;
            s4_reg     <= s4_next;
            s5_reg     <= s5_next;
            s6_reg     <= s6_next;
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ===== design/eno3_face_reconstruction.sv =====
// Top level of the third-order ENO face reconstruction block.
// The block takes one cell-average transaction per clock cycle while s_ready is high and,
// once a component has five values since its last restart, returns one transaction with
// the rounded, saturated values at the plus and minus faces of the middle cell and the
// chosen stencil. The front part updates the component's window on acceptance and places
// the stencil in a four-entry queue, and the back part runs a six-stage arithmetic
// pipeline (differences, stencil choice, face sums, division by 24 in two narrow reciprocal
// multiplications) into the output register. While a result waits in the output register
// with m_ready low the back pipeline holds; the queue keeps taking transactions until it is
// full, at which point s_ready drops. Components at or above COMPONENTS are accepted and
// ignored. Sustained throughput is one transaction per cycle while m_ready stays high.
`timescale 1ns / 1ps

module eno3_face_reconstruction #(
    parameter int COMPONENTS = eno3_pkg::COMPONENTS_DEF,
    parameter int Q_DEPTH    = eno3_pkg::Q_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  eno3_pkg::s_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output eno3_pkg::m_item_t m_data
);
    import eno3_pkg::*;

    logic  q_push, q_full, q_pop, q_empty;
    work_t q_push_data, q_pop_data;

    // Front part: windows, fill counts and stencil issue.
    eno3_front #(
        .COMPONENTS (COMPONENTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full)
    );

    // Queue that decouples the two parts.
    eno3_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // Back part: arithmetic pipeline and output register.
    eno3_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (!q_empty),
        .in_ready (q_pop),
        .in_data  (q_pop_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== design/eno3_checker.sv =====
// Port-level checker for the ENO3 face reconstruction block, with its bind statement.
`timescale 1ns / 1ps
`include "eno3_face_reconstruction_macros.svh"

module eno3_checker #(
    parameter int COMPONENTS = eno3_pkg::COMPONENTS_DEF
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input eno3_pkg::s_item_t s_data,
    input logic              m_valid,
    input logic              m_ready,
    input eno3_pkg::m_item_t m_data
);
    import eno3_pkg::*;

    // A stalled result transaction stays offered.
    `ENO3_ASSERT_NEXT(a_hold_valid, m_valid && !m_ready, m_valid, "result dropped while stalled")

    // A stalled result transaction keeps its payload.
    `ENO3_ASSERT_NEXT(a_hold_data, m_valid && !m_ready, $stable(m_data), "result changed while stalled")

    // A stalled input transaction stays offered with the same payload.
    `ENO3_ASSERT_NEXT(a_hold_input, s_valid && !s_ready, s_valid && $stable(s_data), "input withdrawn while stalled")

    // Reset leaves no result pending and the queue ready for input.
    `ENO3_ASSERT_RESET(a_reset_idle, !aresetn, !m_valid && s_ready, "block not idle after reset")

    // Only components inside the configured range ever produce results.
    `ENO3_ASSERT_NOW(a_comp_range, m_valid, int'(m_data.component_out) < COMPONENTS, "result for an ignored component")

endmodule

bind eno3_face_reconstruction eno3_checker #(
    .COMPONENTS (COMPONENTS)
) u_eno3_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
